FILE: hdl/i2c_ras_pkg.sv
// Shared types and constants of the I2C register access sequencer.
// Holds request, action and status codes, the phase encoding and the item layouts.
// No dependencies; the top level and the checker refer to it by scoped names.
package i2c_ras_pkg;

    // Default number of slots in each ring; one slot always stays free.
    localparam int QUEUE_DEPTH = 8;

    // Stream widths; the tdata widths are padded to whole bytes.
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    // Request kinds carried in the slave-side tuser.
    typedef enum logic [1:0] {
        REQ_ENQUEUE   = 2'd0,
        REQ_POP       = 2'd1,
        REQ_BUS_EVENT = 2'd2
    } t_req;

    // Actions handed to the byte-level bus engine.
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_RESTART = 3'd2,
        ACT_SEND    = 3'd3,
        ACT_RECV    = 3'd4,
        ACT_STOP    = 3'd5
    } t_action;

    // Status codes reported by the bus engine; the low three bits carry no meaning.
    localparam logic [7:0] STATUS_MASK   = 8'hF8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_WADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_RADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RDATA_NACK = 8'h58;

    // Read direction bit of an address byte.
    localparam logic [7:0] ADDR_READ_BIT = 8'h01;

    // Transfer phase, one-hot.
    typedef enum logic [8:0] {
        PH_FIRST_START  = 9'b000000001,
        PH_READ_ADDR    = 9'b000000010,
        PH_READ_REG     = 9'b000000100,
        PH_SECOND_START = 9'b000001000,
        PH_READ_ADDR_2  = 9'b000010000,
        PH_READ_DATA    = 9'b000100000,
        PH_WRITE_ADDR   = 9'b001000000,
        PH_WRITE_REG    = 9'b010000000,
        PH_WRITE_DATA   = 9'b100000000
    } t_phase;

    // One command or response entry, address in the lowest bits.
    typedef struct packed {
        logic       rd;
        logic [7:0] data;
        logic [7:0] reg_idx;
        logic [7:0] addr;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    // Payload of one request, dev_addr in the lowest bits.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] bus_status;
        logic       is_read;
        logic [7:0] wr_data;
        logic [7:0] reg_index;
        logic [7:0] dev_addr;
    } t_in_data;

    localparam int IN_FIELDS_W = $bits(t_in_data);

    // One result item, accepted in the lowest bit.
    typedef struct packed {
        logic       resp_is_read;
        logic [7:0] resp_data;
        logic [7:0] resp_reg;
        logic [7:0] resp_addr;
        logic       resp_valid;
        logic [7:0] tx_byte;
        t_action    bus_action;
        logic       accepted;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

FILE: hdl/i2c_ras_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for both rings of the I2C register access sequencer; no dependencies.
// A read of the address written in the same cycle returns the old contents.
module i2c_ras_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/i2c_register_access_sequencer.sv
// Top level of the I2C register access sequencer.
// Depends on i2c_ras_pkg for codes and layouts and on i2c_ras_ram for both rings.
//
// Usage:
// The slave channel takes one request per transfer. tuser selects the kind:
// enqueue a register command, pop the next read response, or report a bus
// engine status event. The master channel returns exactly one result per
// request: the enqueue acknowledge, the next bus action with its byte, and the
// popped response. Commands and responses sit in two rings of QUEUE_DEPTH
// entries each, held in RAMs with a registered read; each ring keeps
// one slot free. A request waits in the input register, its result in the output register.
// While the receiver does not stall, one request is taken every cycle: the RAM read address
// follows the next head pointer each cycle, and a write to the entry being read is forwarded.
// After reset both rings are empty, the phase is the first start and no result
// is pending; the rings need no clearing pass. When the receiver stalls, the
// result waits in the output register and one more request is held in the
// input register before tready falls.
module i2c_register_access_sequencer #(
    parameter int QUEUE_DEPTH = i2c_ras_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: dev_addr[7:0], reg_index[15:8], wr_data[23:16], is_read[24],
    //        bus_status[32:25], rx_byte[40:33], zero padding above.
    input  logic [i2c_ras_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: req_type[1:0].
    input  logic [i2c_ras_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    // Result channel.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: accepted[0], bus_action[3:1], tx_byte[11:4], resp_valid[12],
    //        resp_addr[20:13], resp_reg[28:21], resp_data[36:29],
    //        resp_is_read[37], zero padding above.
    output logic [i2c_ras_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CMD_W = i2c_ras_pkg::CMD_W;

    // Advance a ring pointer with wrap at the ring depth.
    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Input register.
    logic                     r_in_v;
    i2c_ras_pkg::t_in_data    r_in;
    logic [1:0]               r_in_req;

    // Output register.
    logic                     r_out_v;
    i2c_ras_pkg::t_result     r_out;

    // Sequencer state.
    logic [PTR_W-1:0]         r_cmd_head, n_cmd_head;
    logic [PTR_W-1:0]         r_cmd_tail, n_cmd_tail;
    logic [PTR_W-1:0]         r_resp_head, n_resp_head;
    logic [PTR_W-1:0]         r_resp_tail, n_resp_tail;
    i2c_ras_pkg::t_cmd        r_active, n_active;
    i2c_ras_pkg::t_phase      r_phase, n_phase;

    // Ring ports and forwarding of same-entry writes.
    logic                     cmd_we, resp_we;
    i2c_ras_pkg::t_cmd        cmd_wdata, resp_wdata;
    logic [PTR_W-1:0]         cmd_raddr, resp_raddr;
    logic [CMD_W-1:0]         cmd_rdata, resp_rdata;
    logic                     r_cmd_fwd, r_resp_fwd;
    i2c_ras_pkg::t_cmd        r_cmd_fwd_data, r_resp_fwd_data;
    i2c_ras_pkg::t_cmd        cmd_entry, resp_entry;

    logic                     fire;
    logic                     cmd_empty, cmd_full, resp_empty, resp_full;
    logic [7:0]               status;
    i2c_ras_pkg::t_result     res;

    // Handshakes: a request moves on when the output register is free or drains.
    assign fire       = r_in_v && (!r_out_v || i_m_tready);
    assign o_s_tready = !r_in_v || fire;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = i2c_ras_pkg::OUT_TDATA_W'(r_out);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_s_tready) begin
            r_in_v <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_in     <= i2c_ras_pkg::t_in_data'(i_s_tdata[i2c_ras_pkg::IN_FIELDS_W-1:0]);
            r_in_req <= i_s_tuser;
        end
    end

    // Ring status and the head entries, with writes of the last cycle forwarded.
    assign cmd_empty  = (r_cmd_head == r_cmd_tail);
    assign cmd_full   = (f_next(r_cmd_tail) == r_cmd_head);
    assign resp_empty = (r_resp_head == r_resp_tail);
    assign resp_full  = (f_next(r_resp_tail) == r_resp_head);
    assign cmd_entry  = r_cmd_fwd ? r_cmd_fwd_data : i2c_ras_pkg::t_cmd'(cmd_rdata);
    assign resp_entry = r_resp_fwd ? r_resp_fwd_data : i2c_ras_pkg::t_cmd'(resp_rdata);
    assign status     = r_in.bus_status & i2c_ras_pkg::STATUS_MASK;

    // Request decode and next state.
    always_comb begin
        n_cmd_head  = r_cmd_head;
        n_cmd_tail  = r_cmd_tail;
        n_resp_head = r_resp_head;
        n_resp_tail = r_resp_tail;
        n_active    = r_active;
        n_phase     = r_phase;
        res         = '0;
        cmd_we      = 1'b0;
        resp_we     = 1'b0;
        cmd_wdata   = '{rd: r_in.is_read, data: r_in.wr_data,
                        reg_idx: r_in.reg_index, addr: r_in.dev_addr};
        resp_wdata  = '{rd: r_active.rd, data: r_in.rx_byte,
                        reg_idx: r_active.reg_idx, addr: r_active.addr};
        if (fire) begin
            unique case (r_in_req)
                i2c_ras_pkg::REQ_ENQUEUE: begin
                    if (!cmd_full) begin
                        cmd_we       = 1'b1;
                        n_cmd_tail   = f_next(r_cmd_tail);
                        res.accepted = 1'b1;
                        if (cmd_empty) begin
                            n_phase        = i2c_ras_pkg::PH_FIRST_START;
                            res.bus_action = i2c_ras_pkg::ACT_START;
                        end
                    end
                end
                i2c_ras_pkg::REQ_POP: begin
                    if (!resp_empty) begin
                        n_resp_head      = f_next(r_resp_head);
                        res.resp_valid   = 1'b1;
                        res.resp_addr    = resp_entry.addr;
                        res.resp_reg     = resp_entry.reg_idx;
                        res.resp_data    = resp_entry.data;
                        res.resp_is_read = resp_entry.rd;
                    end
                end
                i2c_ras_pkg::REQ_BUS_EVENT: begin
                    unique case (status)
                        i2c_ras_pkg::ST_START, i2c_ras_pkg::ST_RESTART: begin
                            if (r_phase == i2c_ras_pkg::PH_SECOND_START) begin
                                res.tx_byte    = r_active.addr | i2c_ras_pkg::ADDR_READ_BIT;
                                res.bus_action = i2c_ras_pkg::ACT_SEND;
                                n_phase        = i2c_ras_pkg::PH_READ_ADDR_2;
                            end else if (!cmd_empty) begin
                                n_active       = cmd_entry;
                                n_cmd_head     = f_next(r_cmd_head);
                                n_phase        = cmd_entry.rd ? i2c_ras_pkg::PH_READ_ADDR
                                                              : i2c_ras_pkg::PH_WRITE_ADDR;
                                res.tx_byte    = cmd_entry.addr;
                                res.bus_action = i2c_ras_pkg::ACT_SEND;
                            end else begin
                                res.bus_action = i2c_ras_pkg::ACT_STOP;
                            end
                        end
                        i2c_ras_pkg::ST_WADDR_ACK: begin
                            res.tx_byte    = r_active.reg_idx;
                            res.bus_action = i2c_ras_pkg::ACT_SEND;
                            if (r_phase == i2c_ras_pkg::PH_READ_ADDR) begin
                                n_phase = i2c_ras_pkg::PH_READ_REG;
                            end else if (r_phase == i2c_ras_pkg::PH_WRITE_ADDR) begin
                                n_phase = i2c_ras_pkg::PH_WRITE_REG;
                            end
                        end
                        i2c_ras_pkg::ST_DATA_ACK, i2c_ras_pkg::ST_DATA_NACK: begin
                            if (r_phase == i2c_ras_pkg::PH_READ_REG) begin
                                n_phase        = i2c_ras_pkg::PH_SECOND_START;
                                res.bus_action = i2c_ras_pkg::ACT_RESTART;
                            end else if (r_phase == i2c_ras_pkg::PH_WRITE_REG) begin
                                n_phase        = i2c_ras_pkg::PH_WRITE_DATA;
                                res.tx_byte    = r_active.data;
                                res.bus_action = i2c_ras_pkg::ACT_SEND;
                            end else if (r_phase == i2c_ras_pkg::PH_WRITE_DATA) begin
                                if (!cmd_empty) begin
                                    n_phase        = i2c_ras_pkg::PH_FIRST_START;
                                    res.bus_action = i2c_ras_pkg::ACT_RESTART;
                                end else begin
                                    res.bus_action = i2c_ras_pkg::ACT_STOP;
                                end
                            end
                        end
                        i2c_ras_pkg::ST_RDATA_ACK, i2c_ras_pkg::ST_RDATA_NACK: begin
                            // Received byte joins the active command; a full ring drops it.
                            n_active = resp_wdata;
                            if (!resp_full) begin
                                resp_we     = 1'b1;
                                n_resp_tail = f_next(r_resp_tail);
                            end
                            if (!cmd_empty) begin
                                n_phase        = i2c_ras_pkg::PH_FIRST_START;
                                res.bus_action = i2c_ras_pkg::ACT_RESTART;
                            end else begin
                                n_phase        = i2c_ras_pkg::PH_READ_DATA;
                                res.bus_action = i2c_ras_pkg::ACT_STOP;
                            end
                        end
                        i2c_ras_pkg::ST_RADDR_ACK: begin
                            n_phase        = i2c_ras_pkg::PH_READ_DATA;
                            res.bus_action = i2c_ras_pkg::ACT_RECV;
                        end
                        default: begin
                            if (!cmd_empty) begin
                                n_phase        = i2c_ras_pkg::PH_FIRST_START;
                                res.bus_action = i2c_ras_pkg::ACT_RESTART;
                            end else begin
                                res.bus_action = i2c_ras_pkg::ACT_STOP;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // The rings are read every cycle at the head they will have next cycle.
    assign cmd_raddr  = i_rst_n ? n_cmd_head : '0;
    assign resp_raddr = i_rst_n ? n_resp_head : '0;

    // Sequencer state and write forwarding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_head  <= '0;
            r_cmd_tail  <= '0;
            r_resp_head <= '0;
            r_resp_tail <= '0;
            r_active    <= '0;
            r_phase     <= i2c_ras_pkg::PH_FIRST_START;
            r_cmd_fwd   <= 1'b0;
            r_resp_fwd  <= 1'b0;
        end else begin
            r_cmd_head  <= n_cmd_head;
            r_cmd_tail  <= n_cmd_tail;
            r_resp_head <= n_resp_head;
            r_resp_tail <= n_resp_tail;
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_cmd_fwd   <= cmd_we && (r_cmd_tail == cmd_raddr);
            r_resp_fwd  <= resp_we && (r_resp_tail == resp_raddr);
        end
        r_cmd_fwd_data  <= cmd_wdata;
        r_resp_fwd_data <= resp_wdata;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (fire) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    // Command ring.
    i2c_ras_ram #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_cmd_ram (
        .i_clk  (i_clk),
        .i_we   (cmd_we),
        .i_waddr(r_cmd_tail),
        .i_wdata(CMD_W'(cmd_wdata)),
        .i_raddr(cmd_raddr),
        .o_rdata(cmd_rdata)
    );

    // Response ring.
    i2c_ras_ram #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_resp_ram (
        .i_clk  (i_clk),
        .i_we   (resp_we),
        .i_waddr(r_resp_tail),
        .i_wdata(CMD_W'(resp_wdata)),
        .i_raddr(resp_raddr),
        .o_rdata(resp_rdata)
    );

endmodule

FILE: hdl/i2c_ras_checker.sv
// Port-level checks for the I2C register access sequencer.
// Depends on i2c_ras_pkg for the result layout; bound to the top level below.
module i2c_ras_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [i2c_ras_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    i2c_ras_pkg::t_result res;

    assign res = i2c_ras_pkg::t_result'(o_m_tdata[i2c_ras_pkg::RESULT_W-1:0]);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Requests back up only behind a stalled result.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("request side stalled without a stalled result");

    // A byte goes out only with a send action.
    a_tx_only_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (res.bus_action != i2c_ras_pkg::ACT_SEND) |-> res.tx_byte == 8'h00)
        else $error("tx byte without send action");

    // Response fields are zero unless a response was popped.
    a_resp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !res.resp_valid |->
            (res.resp_addr == 8'h00) && (res.resp_reg == 8'h00) &&
            (res.resp_data == 8'h00) && !res.resp_is_read)
        else $error("response fields set without a popped response");

    // An accepted enqueue at most starts the bus and never pops.
    a_enqueue_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res.accepted |-> !res.resp_valid &&
            ((res.bus_action == i2c_ras_pkg::ACT_NONE) ||
             (res.bus_action == i2c_ras_pkg::ACT_START)))
        else $error("enqueue acknowledge with a foreign action");

endmodule

bind i2c_register_access_sequencer i2c_ras_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);
